// ===== rtl/scta_pkg.sv =====
package scta_pkg;

    // Scancode set 1 codes with a special meaning
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;

    // Number of codes covered by the lookup tables
    localparam logic [7:0] SC_TABLE_ENTRIES = 8'd58;
    localparam int unsigned SC_INDEX_W = 6;

    // Character width and case offset
    localparam int unsigned CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CHAR_CASE_OFS = 7'd32;

    // Result of decoding one scancode
    typedef struct packed {
        logic              has_result;
        logic [CHAR_W-1:0] ch;
    } scta_result_t;

    // Unshifted key map
    function automatic logic [CHAR_W-1:0] plain_char(input logic [SC_INDEX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            6'd1:    c = 7'h1B;   // escape
            6'd2:    c = 7'h31;
            6'd3:    c = 7'h32;
            6'd4:    c = 7'h33;
            6'd5:    c = 7'h34;
            6'd6:    c = 7'h35;
            6'd7:    c = 7'h36;
            6'd8:    c = 7'h37;
            6'd9:    c = 7'h38;
            6'd10:   c = 7'h39;
            6'd11:   c = 7'h30;
            6'd12:   c = 7'h2D;   // -
            6'd13:   c = 7'h3D;   // =
            6'd14:   c = 7'h08;   // backspace
            6'd15:   c = 7'h09;   // tab
            6'd16:   c = 7'h71;   // q
            6'd17:   c = 7'h77;
            6'd18:   c = 7'h65;
            6'd19:   c = 7'h72;
            6'd20:   c = 7'h74;
            6'd21:   c = 7'h79;
            6'd22:   c = 7'h75;
            6'd23:   c = 7'h69;
            6'd24:   c = 7'h6F;
            6'd25:   c = 7'h70;
            6'd26:   c = 7'h5B;   // [
            6'd27:   c = 7'h5D;   // ]
            6'd28:   c = 7'h0A;   // enter
            6'd30:   c = 7'h61;   // a
            6'd31:   c = 7'h73;
            6'd32:   c = 7'h64;
            6'd33:   c = 7'h66;
            6'd34:   c = 7'h67;
            6'd35:   c = 7'h68;
            6'd36:   c = 7'h6A;
            6'd37:   c = 7'h6B;
            6'd38:   c = 7'h6C;
            6'd39:   c = 7'h3B;   // ;
            6'd40:   c = 7'h27;   // '
            6'd41:   c = 7'h60;   // `
            6'd43:   c = 7'h5C;   // backslash
            6'd44:   c = 7'h7A;   // z
            6'd45:   c = 7'h78;
            6'd46:   c = 7'h63;
            6'd47:   c = 7'h76;
            6'd48:   c = 7'h62;
            6'd49:   c = 7'h6E;
            6'd50:   c = 7'h6D;
            6'd51:   c = 7'h2C;   // ,
            6'd52:   c = 7'h2E;   // .
            6'd53:   c = 7'h2F;   // /
            6'd55:   c = 7'h2A;   // keypad *
            6'd57:   c = 7'h20;   // space
            default: c = 7'h00;   // ctrl, shift, alt and codes past the table
        endcase
        return c;
    endfunction

    // Shifted key map
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [SC_INDEX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h21;   // !
            6'd3:    c = 7'h40;   // @
            6'd4:    c = 7'h23;   // #
            6'd5:    c = 7'h24;   // $
            6'd6:    c = 7'h25;   // %
            6'd7:    c = 7'h5E;   // ^
            6'd8:    c = 7'h26;   // &
            6'd9:    c = 7'h2A;   // *
            6'd10:   c = 7'h28;   // (
            6'd11:   c = 7'h29;   // )
            6'd12:   c = 7'h5F;   // _
            6'd13:   c = 7'h2B;   // +
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h51;   // Q
            6'd17:   c = 7'h57;
            6'd18:   c = 7'h45;
            6'd19:   c = 7'h52;
            6'd20:   c = 7'h54;
            6'd21:   c = 7'h59;
            6'd22:   c = 7'h55;
            6'd23:   c = 7'h49;
            6'd24:   c = 7'h4F;
            6'd25:   c = 7'h50;
            6'd26:   c = 7'h7B;   // {
            6'd27:   c = 7'h7D;   // }
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h41;   // A
            6'd31:   c = 7'h53;
            6'd32:   c = 7'h44;
            6'd33:   c = 7'h46;
            6'd34:   c = 7'h47;
            6'd35:   c = 7'h48;
            6'd36:   c = 7'h4A;
            6'd37:   c = 7'h4B;
            6'd38:   c = 7'h4C;
            6'd39:   c = 7'h3A;   // :
            6'd40:   c = 7'h22;   // "
            6'd41:   c = 7'h7E;   // ~
            6'd43:   c = 7'h7C;   // |
            6'd44:   c = 7'h5A;   // Z
            6'd45:   c = 7'h58;
            6'd46:   c = 7'h43;
            6'd47:   c = 7'h56;
            6'd48:   c = 7'h42;
            6'd49:   c = 7'h4E;
            6'd50:   c = 7'h4D;
            6'd51:   c = 7'h3C;   // <
            6'd52:   c = 7'h3E;   // >
            6'd53:   c = 7'h3F;   // ?
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/scta_decode.sv =====
module scta_decode
    import scta_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   code,      // registered scancode
    input  logic         advance,   // registered code leaves this stage
    output scta_result_t result
);

    logic shift_held_reg;
    logic shift_held_next;
    logic caps_on_reg;
    logic caps_on_next;

    logic                  is_shift_make;
    logic                  is_shift_brk;
    logic                  is_caps_make;
    logic                  in_table;
    logic [SC_INDEX_W-1:0] idx;
    logic [CHAR_W-1:0]     base_ch;
    logic                  is_letter;

    // Classify the code
    assign is_shift_make = (code == SC_LSHIFT_MAKE) || (code == SC_RSHIFT_MAKE);
    assign is_shift_brk  = (code == SC_LSHIFT_BRK) || (code == SC_RSHIFT_BRK);
    assign is_caps_make  = (code == SC_CAPS_MAKE);
    assign in_table      = !code[7] && (code < SC_TABLE_ENTRIES);
    assign idx           = code[SC_INDEX_W-1:0];

    // Look up the character and apply shift and caps lock
    assign base_ch   = plain_char(idx);
    assign is_letter = (base_ch >= CHAR_LOWER_A) && (base_ch <= CHAR_LOWER_Z);

    always_comb begin
        result.has_result = in_table && !is_shift_make && !is_caps_make;
        if (is_letter) begin
            result.ch = (shift_held_reg ^ caps_on_reg) ? (base_ch - CHAR_CASE_OFS) : base_ch;
        end else if (shift_held_reg) begin
            result.ch = shifted_char(idx);
        end else begin
            result.ch = base_ch;
        end
    end

    // Update the modifier flags as the code leaves
    always_comb begin
        shift_held_next = shift_held_reg;
        caps_on_next    = caps_on_reg;
        if (advance) begin
            if (is_shift_make) begin
                shift_held_next = 1'b1;
            end else if (is_shift_brk) begin
                shift_held_next = 1'b0;
            end
            if (is_caps_make) begin
                caps_on_next = !caps_on_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_held_reg <= 1'b0;
            caps_on_reg    <= 1'b0;
        end else begin
            shift_held_reg <= shift_held_next;
            caps_on_reg    <= caps_on_next;
        end
    end

endmodule

// ===== rtl/scta_out_reg.sv =====
module scta_out_reg
    import scta_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,      // write a new result
    input  logic [CHAR_W-1:0] load_ch,
    output logic              free,      // register can take a result this cycle
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_ch
);

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] ch_reg;

    // Free when empty or when the held result is taken now
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new result is loaded
    always_ff @(posedge aclk) begin
        if (load) begin
            ch_reg <= load_ch;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_ch     = ch_reg;

endmodule

// ===== rtl/scancode_to_ascii_decoder.sv =====
// Scancode set 1 to ASCII decoder.
//
// Input channel s_*: one raw keyboard scancode byte per transaction; bit 7
// marks a key release. Output channel m_*: one ASCII character per
// transaction, 0 for keys without a character (ctrl, alt and the like).
// Shift make and break codes, the caps-lock make code, other break codes
// and codes past the key table produce no output transaction; the shift
// and caps-lock codes only update the modifier flags.
//
// Path: an accepted byte is loaded into the input register; when it moves
// on, its character is loaded into the output register and shows on m_*.
// Throughput: one byte per cycle, set by the single lookup stage, as long as
// the output register is free or the receiver takes its character.
//
// Reset (aresetn low, synchronous) empties both registers and clears the
// shift and caps-lock flags. When the receiver stalls, the output register
// holds its character; the input register keeps taking bytes until it holds
// one that needs the busy output register, then s_tready drops.
module scancode_to_ascii_decoder
    import scta_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] scan_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [6:0] ascii_char, [7] zero
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_code_reg;
    logic         out_free;
    logic         advance;
    scta_result_t result;
    logic [CHAR_W-1:0] out_ch;

    // Registered code moves on when it needs no output slot or one is free
    assign advance  = in_valid_reg && (!result.has_result || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata;
        end
    end

    scta_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .code    (in_code_reg),
        .advance (advance),
        .result  (result)
    );

    scta_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && result.has_result),
        .load_ch  (result.ch),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_ch     (out_ch)
    );

    assign m_tdata = {1'b0, out_ch};

endmodule
